/* sv/dfr_pkg.sv */
`default_nettype none

package dfr_pkg;

    // Default frame length limit (stored bytes including terminator)
    localparam int MAX_FRAME_DEFAULT = 1024;

    // Framing symbols
    localparam logic [7:0] SYM_DLE      = 8'h10;
    localparam logic [7:0] SYM_ETX      = 8'h03;
    localparam logic [7:0] SYM_SOH      = 8'h01;
    localparam logic [7:0] SYM_NUL      = 8'h00;
    localparam logic [7:0] SYM_SKIPMARK = 8'h2b;
    localparam logic [7:0] SYM_SKIPOK   = 8'h18;

    // Input beat kinds
    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_TIMEOUT = 1'b1;

    // Result beat kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // End-of-frame status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TOO_LONG   = 3'd1,
        ST_TOO_SHORT  = 3'd2,
        ST_BAD_HEADER = 3'd3,
        ST_CHECKSUM   = 3'd4,
        ST_BAD_ESCAPE = 3'd5,
        ST_TIMEOUT    = 3'd6
    } t_status;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        t_status    status;
        logic [9:0] payload_length;
        logic [7:0] command_echo;
        logic       stuffing_anomaly;
        logic       last;
    } t_out_item;

endpackage

`default_nettype wire

/* sv/dle_frame_receiver.sv */
// DLE/ETX reply frame receiver. Takes one received byte (or a timeout) per input
// beat, removes DLE stuffing and the byte after each 0x2b, checks the SOH NUL
// header and the 8-bit checksum, and emits each payload byte as it arrives
// followed by one end-of-frame status beat carrying status, payload length and
// the command echo. Throughput is one input beat per clock while the output
// is not stalled; a beat is held in the input register and its result is
// registered in the output register. Stalls on the output back up into the
// input stall. No clearing pass is needed after reset.
`default_nettype none

module dle_frame_receiver #(
    parameter int MAX_FRAME = dfr_pkg::MAX_FRAME_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire dfr_pkg::t_in_item  i_item,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output dfr_pkg::t_out_item      o_item
);
    import dfr_pkg::*;

    logic      in_valid;
    t_in_item  in_item;
    logic      advance;
    logic      out_free;
    logic      res_valid;
    t_out_item res;

    dfr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (i_item),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    dfr_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_item      (in_item),
        .i_out_free  (out_free),
        .o_advance   (advance),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    dfr_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

/* sv/dfr_in_reg.sv */
`default_nettype none

module dfr_in_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire dfr_pkg::t_in_item i_item,
    input  wire logic              i_advance,
    output logic                   o_valid,
    output dfr_pkg::t_in_item      o_item
);
    import dfr_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     load;

    // Hold the beat while the core cannot take it
    assign o_stall = r_valid && !i_advance;
    assign load    = i_valid && !o_stall;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= load || (r_valid && !i_advance);
        end
    end

    // Capture the beat
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

/* sv/dfr_core.sv */
`default_nettype none

module dfr_core #(
    parameter int MAX_FRAME = dfr_pkg::MAX_FRAME_DEFAULT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire dfr_pkg::t_in_item i_item,
    input  wire logic              i_out_free,
    output logic                   o_advance,
    output logic                   o_res_valid,
    output dfr_pkg::t_out_item     o_res
);
    import dfr_pkg::*;

    localparam int CW = $clog2(MAX_FRAME) + 1;

    // Frame state
    logic          r_esc,    n_esc;
    logic          r_skip,   n_skip;
    logic [CW-1:0] r_count,  n_count;
    logic [7:0]    r_sum,    n_sum;
    logic [7:0]    r_expect, n_expect;
    logic          r_hdr_ok, n_hdr_ok;
    logic [7:0]    r_echo,   n_echo;
    logic          r_anom,   n_anom;

    logic [7:0]    b;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] emitted;
    logic [CW-1:0] plen;
    logic          keep_en;
    logic [CW-1:0] keep_idx;
    logic          fin_en;
    t_status       fin_status;

    assign o_advance = i_valid && i_out_free;
    assign b         = i_item.rx_byte;
    assign cnt_inc   = r_count + CW'(1);

    // Payload bytes emitted so far in this frame
    always_comb begin
        emitted = r_count - CW'(r_esc);
        plen    = (emitted > CW'(4)) ? emitted - CW'(4) : '0;
    end

    // Decode the beat and update the frame state
    always_comb begin
        n_esc       = r_esc;
        n_skip      = r_skip;
        n_count     = r_count;
        n_sum       = r_sum;
        n_expect    = r_expect;
        n_hdr_ok    = r_hdr_ok;
        n_echo      = r_echo;
        n_anom      = r_anom;
        keep_en     = 1'b0;
        keep_idx    = r_count;
        fin_en      = 1'b0;
        fin_status  = ST_OK;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_item.mode == MODE_TIMEOUT) begin
            fin_en     = 1'b1;
            fin_status = ST_TIMEOUT;
        end else if (r_esc) begin
            if (b == SYM_DLE) begin
                // Escaped data DLE, already counted
                n_esc    = 1'b0;
                keep_en  = 1'b1;
                keep_idx = r_count - CW'(1);
            end else if (b == SYM_ETX) begin
                fin_en = 1'b1;
                if (cnt_inc >= CW'(MAX_FRAME)) begin
                    fin_status = ST_TOO_LONG;
                end else if (cnt_inc < CW'(6)) begin
                    fin_status = ST_TOO_SHORT;
                end else if (!r_hdr_ok) begin
                    fin_status = ST_BAD_HEADER;
                end else if (r_sum != r_expect) begin
                    fin_status = ST_CHECKSUM;
                end else begin
                    fin_status = ST_OK;
                end
            end else begin
                fin_en     = 1'b1;
                fin_status = ST_BAD_ESCAPE;
            end
        end else if (r_skip) begin
            // Drop the byte after the skip mark
            if (b != SYM_SKIPOK) begin
                n_anom = 1'b1;
            end
            n_skip = 1'b0;
        end else begin
            n_count = cnt_inc;
            if (cnt_inc >= CW'(MAX_FRAME)) begin
                fin_en     = 1'b1;
                fin_status = ST_TOO_LONG;
            end else if (b == SYM_DLE) begin
                n_esc = 1'b1;
            end else begin
                if (b == SYM_SKIPMARK) begin
                    n_skip = 1'b1;
                end
                keep_en  = 1'b1;
                keep_idx = r_count;
            end
        end

        // Apply a kept byte: header, checksum, echo, payload
        if (keep_en) begin
            if (keep_idx == CW'(0) && b != SYM_SOH) begin
                n_hdr_ok = 1'b0;
            end
            if (keep_idx == CW'(1) && b != SYM_NUL) begin
                n_hdr_ok = 1'b0;
            end
            if (keep_idx == CW'(2)) begin
                n_expect = b;
            end
            if (keep_idx >= CW'(3)) begin
                n_sum = r_sum + b;
            end
            if (keep_idx == CW'(3)) begin
                n_echo = b;
            end
            if (keep_idx >= CW'(4)) begin
                o_res_valid            = 1'b1;
                o_res.kind             = KIND_DATA;
                o_res.data_byte        = b;
                o_res.status           = ST_OK;
                o_res.payload_length   = '0;
                o_res.command_echo     = r_echo;
                o_res.stuffing_anomaly = r_anom;
                o_res.last             = 1'b0;
            end
        end

        // Close the frame and return to the idle frame state
        if (fin_en) begin
            o_res_valid            = 1'b1;
            o_res.kind             = KIND_END;
            o_res.data_byte        = '0;
            o_res.status           = fin_status;
            o_res.payload_length   = 10'(plen);
            o_res.command_echo     = r_echo;
            o_res.stuffing_anomaly = r_anom;
            o_res.last             = 1'b1;
            n_esc    = 1'b0;
            n_skip   = 1'b0;
            n_count  = '0;
            n_sum    = 8'd1;
            n_expect = '0;
            n_hdr_ok = 1'b1;
            n_echo   = '0;
            n_anom   = 1'b0;
        end
    end

    // Advance the frame state on each processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc    <= 1'b0;
            r_skip   <= 1'b0;
            r_count  <= '0;
            r_sum    <= 8'd1;
            r_expect <= '0;
            r_hdr_ok <= 1'b1;
            r_echo   <= '0;
            r_anom   <= 1'b0;
        end else if (o_advance) begin
            r_esc    <= n_esc;
            r_skip   <= n_skip;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_expect <= n_expect;
            r_hdr_ok <= n_hdr_ok;
            r_echo   <= n_echo;
            r_anom   <= n_anom;
        end
    end

endmodule

`default_nettype wire

/* sv/dfr_out_reg.sv */
`default_nettype none

module dfr_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire dfr_pkg::t_out_item i_res,
    output logic                    o_free,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output dfr_pkg::t_out_item      o_item
);
    import dfr_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // Slot opens when empty or being taken this cycle
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_item <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
    import dfr_pkg::*;

    localparam int FRAME_LIMIT  = MAX_FRAME_DEFAULT;
    localparam int RANDOM_ITEMS = 720;
    localparam int TAIL_ITEMS   = 120;

    typedef enum {END_ETX, END_BAD_ESC, END_TIMEOUT, END_SHORT} t_ending;

    // One raw beat for the receiver, or a marker that holds the sender until drained
    typedef struct {
        t_in_item beat;
        bit       pause;
    } t_stim;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    t_in_item  i_item  = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_item;

    dle_frame_receiver #(
        .MAX_FRAME (FRAME_LIMIT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always #5 i_clk = ~i_clk;

    t_stim       rx_stream_q[$];
    t_out_item   deframed_q[$];
    logic [7:0]  body_q[$];
    logic [7:0]  tail_q[$];
    int unsigned odd_skip_pct = 0;

    int unsigned cycles      = 0;
    int unsigned cycle_limit = 32'hffff_ffff;
    int unsigned beats_sent  = 0;
    int unsigned data_seen   = 0;
    int unsigned pauses      = 0;
    int unsigned fail_count  = 0;
    int unsigned shown       = 0;
    int unsigned ends_by_status[8];
    bit          in_taken    = 1'b0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;
    int unsigned gap_pct     = 0;
    int unsigned stall_pct   = 0;

    // Deframer state as the block should hold it
    logic        esc_pend;
    logic        skip_pend;
    int unsigned stored;
    logic [7:0]  run_sum;
    logic [7:0]  hdr_sum;
    logic        hdr_ok;
    logic [7:0]  echo;
    logic        anomaly;

    function automatic void clear_frame();
        esc_pend  = 1'b0;
        skip_pend = 1'b0;
        stored    = 0;
        run_sum   = 8'd1;
        hdr_sum   = 8'd0;
        hdr_ok    = 1'b1;
        echo      = 8'd0;
        anomaly   = 1'b0;
    endfunction

    initial clear_frame();

    function automatic void close_frame(t_status st, int unsigned plen);
        t_out_item r;
        r                  = '0;
        r.kind             = KIND_END;
        r.status           = st;
        r.payload_length   = plen[9:0];
        r.command_echo     = echo;
        r.stuffing_anomaly = anomaly;
        r.last             = 1'b1;
        deframed_q.push_back(r);
        clear_frame();
    endfunction

    // Check header positions, accumulate the sum and emit payload bytes
    function automatic void take_kept(logic [7:0] b, int unsigned idx);
        t_out_item r;
        if (idx == 0 && b != SYM_SOH) hdr_ok = 1'b0;
        if (idx == 1 && b != SYM_NUL) hdr_ok = 1'b0;
        if (idx == 2) hdr_sum = b;
        if (idx >= 3) run_sum = run_sum + b;
        if (idx == 3) echo = b;
        if (idx >= 4) begin
            r                  = '0;
            r.kind             = KIND_DATA;
            r.data_byte        = b;
            r.status           = ST_OK;
            r.command_echo     = echo;
            r.stuffing_anomaly = anomaly;
            r.last             = 1'b0;
            deframed_q.push_back(r);
        end
    endfunction

    function automatic void deframe_beat(t_in_item beat);
        int unsigned plen;
        int unsigned idx;
        logic [7:0]  b;
        b    = beat.rx_byte;
        plen = stored - (esc_pend ? 1 : 0);
        plen = (plen > 4) ? plen - 4 : 0;
        if (beat.mode == MODE_TIMEOUT) begin
            close_frame(ST_TIMEOUT, plen);
        end else if (esc_pend) begin
            if (b == SYM_DLE) begin
                esc_pend = 1'b0;
                take_kept(b, stored - 1);
            end else if (b == SYM_ETX) begin
                stored++;
                if (stored >= FRAME_LIMIT)   close_frame(ST_TOO_LONG, plen);
                else if (stored < 6)         close_frame(ST_TOO_SHORT, plen);
                else if (!hdr_ok)            close_frame(ST_BAD_HEADER, plen);
                else if (run_sum != hdr_sum) close_frame(ST_CHECKSUM, plen);
                else                         close_frame(ST_OK, plen);
            end else begin
                close_frame(ST_BAD_ESCAPE, plen);
            end
        end else if (skip_pend) begin
            // drop the byte after the skip mark, flag it unless it is the expected one
            if (b != SYM_SKIPOK) anomaly = 1'b1;
            skip_pend = 1'b0;
        end else begin
            idx = stored;
            stored++;
            if (stored >= FRAME_LIMIT) begin
                close_frame(ST_TOO_LONG, plen);
            end else if (b == SYM_DLE) begin
                esc_pend = 1'b1;
            end else begin
                if (b == SYM_SKIPMARK) skip_pend = 1'b1;
                take_kept(b, idx);
            end
        end
    endfunction

    function automatic string show_beat(t_out_item r);
        return $sformatf(
            "kind=%0d data=%02h status=%0d len=%0d echo=%02h anomaly=%0d last=%0d",
            r.kind, r.data_byte, r.status, r.payload_length, r.command_echo,
            r.stuffing_anomaly, r.last);
    endfunction

    function automatic void report(string what, t_out_item want, t_out_item got, bit has_want);
        fail_count++;
        if (shown < 10) begin
            shown++;
            $display("[%0t] %s", $time, what);
            if (has_want) $display("    expected %s", show_beat(want));
            $display("    actual   %s", show_beat(got));
        end
    endfunction

    // ---------------------------------------------------------------- stimulus builders

    function automatic void put_beat(logic mode, logic [7:0] b, bit pause);
        t_stim s;
        s.beat.mode    = mode;
        s.beat.rx_byte = b;
        s.pause        = pause;
        rx_stream_q.push_back(s);
    endfunction

    function automatic void put_raw(logic [7:0] b);
        put_beat(MODE_BYTE, b, 1'b0);
    endfunction

    // Stuff a kept byte: double a DLE, follow a skip mark with the byte to drop
    function automatic void put_kept(logic [7:0] b);
        put_raw(b);
        if (b == SYM_DLE) begin
            put_raw(SYM_DLE);
        end else if (b == SYM_SKIPMARK) begin
            if (tail_q.size() > 0)
                put_raw(tail_q.pop_front());
            else if ($urandom_range(0, 99) >= odd_skip_pct)
                put_raw(SYM_SKIPOK);
            else if ($urandom_range(0, 3) == 0)
                put_raw(SYM_DLE);
            else
                put_raw(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void fill_body(int unsigned n, bit plain);
        logic [7:0] b;
        body_q.delete();
        repeat (n) begin
            case ($urandom_range(0, 15))
                0:       b = SYM_DLE;
                1:       b = SYM_SKIPMARK;
                2:       b = SYM_ETX;
                3:       b = SYM_SKIPOK;
                default: b = 8'($urandom_range(0, 255));
            endcase
            if (plain && (b == SYM_DLE || b == SYM_SKIPMARK)) b = 8'h55;
            body_q.push_back(b);
        end
    endfunction

    // Frame around body_q with optional header or sum damage and a chosen ending
    function automatic void put_frame(logic [7:0] cmd, bit bad_hdr, bit bad_sum,
                                      t_ending how);
        logic [7:0]  kept[$];
        logic [7:0]  sum;
        logic [7:0]  esc_bad;
        int unsigned cut;
        sum = 8'd1 + cmd;
        foreach (body_q[i]) sum = sum + body_q[i];
        kept.push_back(SYM_SOH);
        kept.push_back(SYM_NUL);
        if (bad_hdr) begin
            if ($urandom_range(0, 1)) kept[0] = SYM_SOH ^ 8'($urandom_range(1, 255));
            else                      kept[1] = SYM_NUL ^ 8'($urandom_range(1, 255));
        end
        kept.push_back(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
        kept.push_back(cmd);
        foreach (body_q[i]) kept.push_back(body_q[i]);
        case (how)
            END_SHORT:               cut = $urandom_range(0, 3);
            END_BAD_ESC, END_TIMEOUT: cut = $urandom_range(0, kept.size());
            default:                 cut = kept.size();
        endcase
        for (int i = 0; i < cut; i++) put_kept(kept[i]);
        case (how)
            END_BAD_ESC: begin
                esc_bad = 8'($urandom_range(0, 255));
                if (esc_bad == SYM_DLE || esc_bad == SYM_ETX) esc_bad = 8'ha5;
                put_raw(SYM_DLE);
                put_raw(esc_bad);
            end
            END_TIMEOUT: put_beat(MODE_TIMEOUT, 8'($urandom_range(0, 255)), 1'b0);
            default: begin
                put_raw(SYM_DLE);
                put_raw(SYM_ETX);
            end
        endcase
    endfunction

    function automatic int unsigned pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 20;
            default: return 45;
        endcase
    endfunction

    // ---------------------------------------------------------------- driver

    // Present the next beat or idle; hold the beat until it is taken
    always @(negedge i_clk) begin : drive_beats
        t_stim nxt;
        bit    tail;
        if (cycles % 128 == 0) begin
            gap_pct   = pick_pct();
            stall_pct = pick_pct();
        end
        tail = rx_stream_q.size() < TAIL_ITEMS;
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (rx_stream_q.size() == 0) begin
                i_valid <= 1'b0;
            end else if (rx_stream_q[0].pause) begin
                i_valid <= 1'b0;
                if (deframed_q.size() == 0) begin
                    void'(rx_stream_q.pop_front());
                    pauses++;
                end
            end else if (!tail && $urandom_range(0, 99) < gap_pct) begin
                gap_left = $urandom_range(0, 12);
                i_valid <= 1'b0;
            end else begin
                nxt = rx_stream_q.pop_front();
                i_item  <= nxt.beat;
                i_valid <= 1'b1;
            end
        end
        // stall the result side in bursts
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (i_rst_n && !tail && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 12);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- monitor

    // Predict on each accepted input beat, check each accepted result beat
    always @(posedge i_clk) begin : watch_beats
        t_out_item want;
        cycles++;
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            beats_sent++;
            deframe_beat(i_item);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (deframed_q.size() == 0) begin
                report("result beat with nothing expected", o_item, o_item, 1'b0);
            end else begin
                want = deframed_q.pop_front();
                if (o_item.kind !== want.kind || o_item.data_byte !== want.data_byte ||
                    o_item.status !== want.status ||
                    o_item.payload_length !== want.payload_length ||
                    o_item.command_echo !== want.command_echo ||
                    o_item.stuffing_anomaly !== want.stuffing_anomaly ||
                    o_item.last !== want.last)
                    report("result beat mismatch", want, o_item, 1'b1);
                if (want.kind == KIND_END) ends_by_status[want.status]++;
                else                       data_seen++;
            end
        end
        if (cycles > cycle_limit) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin : run_test
        int unsigned base;
        int unsigned r;
        bit          paused_once;
        logic [7:0]  cmd;
        paused_once = 1'b0;

        // Directed frames: extremes, dropped DLE, each error but too long and status priority
        put_beat(MODE_TIMEOUT, 8'hff, 1'b0);
        body_q.delete();
        put_frame(8'h00, 1'b0, 1'b0, END_ETX);
        body_q = '{8'h00, 8'hff, SYM_DLE, SYM_SKIPMARK, SYM_ETX};
        put_frame(8'hff, 1'b0, 1'b0, END_ETX);
        tail_q = '{SYM_DLE, 8'h77};
        body_q = '{SYM_SKIPMARK, 8'h42, SYM_SKIPMARK};
        put_frame(8'h5a, 1'b0, 1'b0, END_ETX);
        fill_body(3, 1'b0);
        put_frame(8'h81, 1'b0, 1'b0, END_BAD_ESC);
        body_q.delete();
        put_frame(8'h11, 1'b1, 1'b0, END_SHORT);
        fill_body(2, 1'b0);
        put_frame(8'h22, 1'b1, 1'b1, END_ETX);
        fill_body(2, 1'b0);
        put_frame(8'h33, 1'b0, 1'b1, END_ETX);
        fill_body(4, 1'b0);
        put_frame(8'h44, 1'b0, 1'b0, END_TIMEOUT);
        put_beat(MODE_BYTE, 8'h00, 1'b1);

        // Random traffic: mostly well-formed frames, some damaged, some line noise
        base = rx_stream_q.size();
        while (rx_stream_q.size() < base + RANDOM_ITEMS) begin
            if (!paused_once && rx_stream_q.size() >= base + RANDOM_ITEMS / 2) begin
                put_beat(MODE_BYTE, 8'h00, 1'b1);
                paused_once = 1'b1;
            end
            odd_skip_pct = ($urandom_range(0, 4) == 0) ? 50 : 0;
            cmd = 8'($urandom_range(0, 255));
            fill_body(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(0, 12), 1'b0);
            r = $urandom_range(0, 99);
            if (r < 55)      put_frame(cmd, 1'b0, 1'b0, END_ETX);
            else if (r < 63) put_frame(cmd, 1'b1, 1'b0, END_ETX);
            else if (r < 71) put_frame(cmd, 1'b0, 1'b1, END_ETX);
            else if (r < 76) put_frame(cmd, 1'b1, 1'b1, END_ETX);
            else if (r < 82) put_frame(cmd, 1'b0, 1'b0, END_BAD_ESC);
            else if (r < 88) put_frame(cmd, 1'b0, 1'b0, END_TIMEOUT);
            else if (r < 92) put_frame(cmd, 1'($urandom_range(0, 1)), 1'b0, END_SHORT);
            else if (r < 97) begin
                repeat ($urandom_range(1, 6)) put_raw(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1))
                    put_beat(MODE_TIMEOUT, 8'($urandom_range(0, 255)), 1'b0);
            end else begin
                put_beat(MODE_TIMEOUT, 8'($urandom_range(0, 255)), 1'b0);
            end
        end
        cycle_limit = rx_stream_q.size() * 40 + 20000;

        // Hold reset, then release it on a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain, then let the pipeline settle
        while (rx_stream_q.size() != 0 || i_valid || deframed_q.size() != 0)
            @(negedge i_clk);
        repeat (12) @(posedge i_clk);

        if (deframed_q.size() != 0) begin
            fail_count++;
            $display("%0d expected result beats never arrived", deframed_q.size());
        end
        $display("Sent %0d input beats over %0d cycles with %0d drain pauses;",
                 beats_sent, cycles, pauses);
        $display("checked %0d payload bytes", data_seen);
        $display("Frame ends: ok %0d, too long %0d, too short %0d, bad header %0d,",
                 ends_by_status[ST_OK], ends_by_status[ST_TOO_LONG],
                 ends_by_status[ST_TOO_SHORT], ends_by_status[ST_BAD_HEADER]);
        $display("            checksum %0d, bad escape %0d, timeout %0d",
                 ends_by_status[ST_CHECKSUM], ends_by_status[ST_BAD_ESCAPE],
                 ends_by_status[ST_TIMEOUT]);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d failures", fail_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
sv/dfr_pkg.sv
sv/dfr_in_reg.sv
sv/dfr_core.sv
sv/dfr_out_reg.sv
sv/dle_frame_receiver.sv
tb/tb.sv
